>>> rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
// expects clk and rst to be visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check that is off while rst is high
`define SPSP_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also runs through reset
`define SPSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/spsp_pkg.sv
// types and constants of the sprite screen projection core
// no dependencies
`default_nettype none

package spsp_pkg;

  localparam int VEC_FRAC   = 14;
  localparam int DEPTH_FRAC = 8;

  // quotient bits resolved by each divider, and its latency in cycles
  localparam int DIV_Q_W = 24;
  localparam int DIV_LAT = DIV_Q_W + 1;

  localparam logic [DIV_Q_W-1:0] DEPTH_POS_MAX = DIV_Q_W'(8388607);
  localparam logic [DIV_Q_W-1:0] DEPTH_NEG_MAX = DIV_Q_W'(8388608);
  localparam logic [DIV_Q_W-1:0] COL_POS_MAX   = DIV_Q_W'(32767);
  localparam logic [DIV_Q_W-1:0] COL_NEG_MAX   = DIV_Q_W'(32768);
  localparam logic [DIV_Q_W-1:0] EXT_MAX       = DIV_Q_W'(32767);

  typedef enum logic [2:0] {
    REG_CAM_POS_X   = 3'd0,
    REG_CAM_POS_Y   = 3'd1,
    REG_VIEW_DIR_X  = 3'd2,
    REG_VIEW_DIR_Y  = 3'd3,
    REG_CAM_PLANE_X = 3'd4,
    REG_CAM_PLANE_Y = 3'd5,
    REG_SCREEN_W    = 3'd6,
    REG_SCREEN_H    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] obj_x;
    logic [15:0] obj_y;
  } obj_t;

  typedef struct packed {
    logic               in_front;
    logic signed [23:0] depth;
    logic signed [15:0] center_col;
    logic [14:0]        extent;
    logic [10:0]        top_row;
    logic [11:0]        bottom_row;
    logic [14:0]        left_col;
    logic signed [15:0] right_col;
    logic               saturated;
  } res_t;

  // per-item flags that ride alongside the dividers
  typedef struct packed {
    logic det_zero;
    logic ny_zero;
    logic nx_pos;
    logic nx_neg;
    logic front;
    logic depth_neg;
    logic col_neg;
  } side_t;

endpackage

`default_nettype wire

>>> rtl/spsp_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// uses no package
`default_nettype none

module spsp_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 34,
  parameter int Q_W   = 24
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo,
  output logic             ovf
);

  localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [W-1:0]     rem [0:Q_W-1];
  logic [DEN_W-1:0] dv  [0:Q_W-1];
  logic [Q_W-1:0]   qv  [0:Q_W];
  logic             ov  [0:Q_W];

  always_ff @(posedge clk) begin
    rem[0] <= W'(num);
    dv[0]  <= den;
    qv[0]  <= '0;
    // quotient does not fit in Q_W bits
    ov[0]  <= W'(num) >= (W'(den) << Q_W);
    for (int k = 1; k < Q_W; k++) begin
      rem[k] <= (rem[k-1] >= (W'(dv[k-1]) << (Q_W - k))) ?
                rem[k-1] - (W'(dv[k-1]) << (Q_W - k)) : rem[k-1];
      dv[k]  <= dv[k-1];
    end
    for (int k = 1; k <= Q_W; k++) begin
      qv[k] <= qv[k-1] |
               (Q_W'(rem[k-1] >= (W'(dv[k-1]) << (Q_W - k))) << (Q_W - k));
      ov[k] <= ov[k-1];
    end
  end

  assign quo = qv[Q_W];
  assign ovf = ov[Q_W];

endmodule

`default_nettype wire

>>> rtl/sprite_screen_projection_core.sv
// top level of the sprite screen projection core
// depends on spsp_pkg, spsp_div and assert_macros.svh
`default_nettype none

// Projects one sprite map position per clock through the configured camera.
// An item is taken at every edge with start high (busy is never raised) and
// its result shows on result, with done high for one cycle, after it has
// passed through every stage. The latency is set by the three parallel
// restoring dividers that resolve one of their 24 quotient bits per stage;
// five stages of offset, multiply and sign handling sit in front of them
// and two stages of clamping and draw bounds behind. The result side cannot
// be held off and never needs to be. Configuration registers must be
// written only while no item is in flight; the core does not enforce it.

`include "assert_macros.svh"

module sprite_screen_projection_core #(
  parameter int POS_FRAC_BITS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  spsp_pkg::obj_t obj,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [15:0]    cfg_data,
  output logic           done,
  output spsp_pkg::res_t result
);

  import spsp_pkg::*;

  localparam int DEPTH_SH  = VEC_FRAC + DEPTH_FRAC - POS_FRAC_BITS;
  localparam int D_NUM_W   = 34 + DEPTH_SH;
  localparam int D_DEN_W   = 33;
  localparam int C_NUM_W   = 46;
  localparam int C_DEN_W   = 34;
  localparam int E_NUM_W   = 45 + POS_FRAC_BITS;
  localparam int E_DEN_W   = 34 + VEC_FRAC;
  localparam int TOTAL_LAT = 8 + DIV_Q_W;

  // configuration
  logic [15:0]        cam_pos_x, cam_pos_y;
  logic signed [15:0] view_dir_x, view_dir_y, cam_plane_x, cam_plane_y;
  logic [11:0]        screen_width, screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_pos_x     <= 16'd0;
      cam_pos_y     <= 16'd0;
      view_dir_x    <= 16'sd16384;
      view_dir_y    <= 16'sd0;
      cam_plane_x   <= 16'sd0;
      cam_plane_y   <= 16'sd10813;
      screen_width  <= 12'd640;
      screen_height <= 12'd480;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CAM_POS_X:   cam_pos_x     <= cfg_data;
        REG_CAM_POS_Y:   cam_pos_y     <= cfg_data;
        REG_VIEW_DIR_X:  view_dir_x    <= $signed(cfg_data);
        REG_VIEW_DIR_Y:  view_dir_y    <= $signed(cfg_data);
        REG_CAM_PLANE_X: cam_plane_x   <= $signed(cfg_data);
        REG_CAM_PLANE_Y: cam_plane_y   <= $signed(cfg_data);
        REG_SCREEN_W:    screen_width  <= cfg_data[11:0];
        REG_SCREEN_H:    screen_height <= cfg_data[11:0];
        default:         cam_pos_x     <= cam_pos_x;
      endcase
    end
  end

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // valid bits
  logic               s1_vld, s2_vld, s3_vld, s4_vld, s5_vld, f1_vld;
  logic [DIV_LAT-1:0] side_vld;

  // stage 1: offsets from the camera
  logic signed [16:0] s1_dx, s1_dy;
  // stage 2: products
  logic signed [32:0] s2_dry_dx, s2_drx_dy, s2_ply_dx, s2_plx_dy;
  logic signed [31:0] s2_det_a, s2_det_b;
  // stage 3: sums
  logic signed [33:0] s3_nx, s3_ny;
  logic signed [32:0] s3_det;
  // stage 4: magnitudes and the centre numerator
  logic signed [34:0] nx_plus_ny;
  logic signed [45:0] s4_cnum;
  logic [33:0]        s4_ny_mag;
  logic [32:0]        s4_det_mag;
  logic               s4_det_zero, s4_ny_zero, s4_nx_pos, s4_nx_neg;
  logic               s4_ny_neg, s4_det_neg;
  // stage 5: divider operands
  logic [D_NUM_W-1:0] s5_dnum;
  logic [D_DEN_W-1:0] s5_dden;
  logic [C_NUM_W-1:0] s5_cnum;
  logic [C_DEN_W-1:0] s5_cden;
  logic [E_NUM_W-1:0] s5_enum;
  logic [E_DEN_W-1:0] s5_eden;
  side_t              s5_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
    end else begin
      s1_vld <= accept;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
    end
  end

  assign nx_plus_ny = 35'(s3_nx) + 35'(s3_ny);

  always_ff @(posedge clk) begin
    s1_dx <= $signed({1'b0, obj.obj_x}) - $signed({1'b0, cam_pos_x});
    s1_dy <= $signed({1'b0, obj.obj_y}) - $signed({1'b0, cam_pos_y});

    s2_dry_dx <= 33'(view_dir_y) * 33'(s1_dx);
    s2_drx_dy <= 33'(view_dir_x) * 33'(s1_dy);
    s2_ply_dx <= 33'(cam_plane_y) * 33'(s1_dx);
    s2_plx_dy <= 33'(cam_plane_x) * 33'(s1_dy);
    s2_det_a  <= 32'(cam_plane_x) * 32'(view_dir_y);
    s2_det_b  <= 32'(view_dir_x) * 32'(cam_plane_y);

    s3_nx  <= 34'(s2_drx_dy) - 34'(s2_dry_dx);
    s3_ny  <= 34'(s2_plx_dy) - 34'(s2_ply_dx);
    s3_det <= 33'(s2_det_a) - 33'(s2_det_b);

    s4_cnum     <= 46'(nx_plus_ny) * 46'($signed({1'b0, screen_width[11:1]}));
    s4_ny_mag   <= s3_ny[33] ? 34'(-s3_ny) : 34'(s3_ny);
    s4_det_mag  <= s3_det[32] ? 33'(-s3_det) : 33'(s3_det);
    s4_det_zero <= (s3_det == '0);
    s4_ny_zero  <= (s3_ny == '0);
    s4_nx_pos   <= !s3_nx[33] && (s3_nx != '0);
    s4_nx_neg   <= s3_nx[33];
    s4_ny_neg   <= s3_ny[33];
    s4_det_neg  <= s3_det[32];

    s5_dnum <= {s4_ny_mag, {DEPTH_SH{1'b0}}};
    s5_dden <= s4_det_mag;
    s5_cnum <= s4_cnum[45] ? C_NUM_W'(-s4_cnum) : C_NUM_W'(s4_cnum);
    s5_cden <= s4_ny_mag;
    s5_enum <= {45'(screen_height) * 45'(s4_det_mag), {POS_FRAC_BITS{1'b0}}};
    s5_eden <= {s4_ny_mag, {VEC_FRAC{1'b0}}};
    s5_side.det_zero  <= s4_det_zero;
    s5_side.ny_zero   <= s4_ny_zero;
    s5_side.nx_pos    <= s4_nx_pos;
    s5_side.nx_neg    <= s4_nx_neg;
    s5_side.front     <= (s4_ny_neg == s4_det_neg);
    s5_side.depth_neg <= s4_ny_neg ^ s4_det_neg;
    s5_side.col_neg   <= s4_cnum[45] ^ s4_ny_neg;
  end

  // dividers
  logic [DIV_Q_W-1:0] dq, cq, eq;
  logic               dq_ov, cq_ov, eq_ov;

  spsp_div #(.NUM_W(D_NUM_W), .DEN_W(D_DEN_W), .Q_W(DIV_Q_W)) u_div_depth (
    .clk (clk), .num (s5_dnum), .den (s5_dden), .quo (dq), .ovf (dq_ov)
  );

  spsp_div #(.NUM_W(C_NUM_W), .DEN_W(C_DEN_W), .Q_W(DIV_Q_W)) u_div_col (
    .clk (clk), .num (s5_cnum), .den (s5_cden), .quo (cq), .ovf (cq_ov)
  );

  spsp_div #(.NUM_W(E_NUM_W), .DEN_W(E_DEN_W), .Q_W(DIV_Q_W)) u_div_ext (
    .clk (clk), .num (s5_enum), .den (s5_eden), .quo (eq), .ovf (eq_ov)
  );

  // flags delayed to line up with the quotients
  side_t side_pipe [0:DIV_LAT-1];
  side_t sd;

  always_ff @(posedge clk) begin
    side_pipe[0] <= s5_side;
    for (int k = 1; k < DIV_LAT; k++) begin
      side_pipe[k] <= side_pipe[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_vld <= '0;
    end else begin
      side_vld <= {side_vld[DIV_LAT-2:0], s5_vld};
    end
  end

  assign sd = side_pipe[DIV_LAT-1];

  // stage f1: signs, saturation and the special cases
  logic               f1_front, f1_front_next;
  logic signed [23:0] f1_depth, f1_depth_next;
  logic signed [15:0] f1_center, f1_center_next;
  logic [14:0]        f1_ext, f1_ext_next;
  logic               f1_sat, f1_sat_next;
  logic [15:0]        half_w;

  assign half_w = 16'({5'b0, screen_width[11:1]});

  always_comb begin
    f1_front_next  = 1'b0;
    f1_depth_next  = '0;
    f1_center_next = $signed(half_w);
    f1_ext_next    = '0;
    f1_sat_next    = 1'b1;
    priority if (sd.det_zero) begin
      f1_sat_next = 1'b1;
    end else if (sd.ny_zero) begin
      f1_ext_next = 15'h7FFF;
      if (sd.nx_pos) begin
        f1_center_next = 16'sh7FFF;
      end else if (sd.nx_neg) begin
        f1_center_next = 16'sh8000;
      end
    end else begin
      f1_front_next = sd.front;
      f1_sat_next   = 1'b0;
      if (sd.depth_neg) begin
        if (dq_ov || dq > DEPTH_NEG_MAX) begin
          f1_depth_next = 24'sh800000;
          f1_sat_next   = 1'b1;
        end else begin
          f1_depth_next = $signed(24'(DIV_Q_W'(0) - dq));
        end
      end else begin
        if (dq_ov || dq > DEPTH_POS_MAX) begin
          f1_depth_next = 24'sh7FFFFF;
          f1_sat_next   = 1'b1;
        end else begin
          f1_depth_next = $signed(dq[23:0]);
        end
      end
      if (sd.col_neg) begin
        if (cq_ov || cq > COL_NEG_MAX) begin
          f1_center_next = 16'sh8000;
          f1_sat_next    = 1'b1;
        end else begin
          f1_center_next = $signed(16'd0 - cq[15:0]);
        end
      end else begin
        if (cq_ov || cq > COL_POS_MAX) begin
          f1_center_next = 16'sh7FFF;
          f1_sat_next    = 1'b1;
        end else begin
          f1_center_next = $signed(cq[15:0]);
        end
      end
      if (eq_ov || eq > EXT_MAX) begin
        f1_ext_next = 15'h7FFF;
        f1_sat_next = 1'b1;
      end else begin
        f1_ext_next = eq[14:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    f1_front  <= f1_front_next;
    f1_depth  <= f1_depth_next;
    f1_center <= f1_center_next;
    f1_ext    <= f1_ext_next;
    f1_sat    <= f1_sat_next;
  end

  // stage f2: draw bounds
  logic [13:0]        half_ext;
  logic [10:0]        half_h;
  logic signed [15:0] top_raw;
  logic [14:0]        bot_raw;
  logic signed [16:0] left_raw, right_raw;
  res_t               result_next;

  assign half_ext  = f1_ext[14:1];
  assign half_h    = screen_height[11:1];
  assign top_raw   = $signed({5'b0, half_h}) - $signed({2'b0, half_ext});
  assign bot_raw   = 15'(half_ext) + 15'(half_h);
  assign left_raw  = 17'(f1_center) - $signed({3'b0, half_ext});
  assign right_raw = 17'(f1_center) + $signed({3'b0, half_ext});

  always_comb begin
    result_next.in_front   = f1_front;
    result_next.depth      = f1_depth;
    result_next.center_col = f1_center;
    result_next.extent     = f1_ext;
    result_next.saturated  = f1_sat;
    result_next.top_row    = top_raw[15] ? 11'd0 : top_raw[10:0];
    if (bot_raw >= 15'(screen_height)) begin
      result_next.bottom_row = (screen_height == 12'd0) ? 12'd0 : screen_height - 12'd1;
    end else begin
      result_next.bottom_row = bot_raw[11:0];
    end
    result_next.left_col = left_raw[16] ? 15'd0 : left_raw[14:0];
    if (right_raw >= $signed({5'b0, screen_width})) begin
      result_next.right_col = $signed(16'(screen_width) - 16'd1);
    end else begin
      result_next.right_col = right_raw[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      f1_vld <= side_vld[DIV_LAT-1];
      done   <= f1_vld;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  `SPSP_ASSERT_CLK(a_latency, accept |-> ##TOTAL_LAT done, "item result missing at fixed latency")
  `SPSP_ASSERT_CLK(a_front_sign, done && result.in_front |-> !result.depth[23], "in front with negative depth")
  `SPSP_ASSERT_CLK(a_top_bound, done |-> result.top_row <= screen_height[11:1], "top row below screen middle")
  `SPSP_ASSERT_CLK(a_right_bound, done |-> result.right_col < $signed({4'b0, screen_width}), "right column past screen")
  `SPSP_ASSERT_ALWAYS(a_reset_quiet, $past(rst) |-> !done, "result strobe right after reset")

endmodule

`default_nettype wire
